/* rtl/core/cr3_pkg.sv */
// Shared types and constants for the 3x3 Cramer's rule solver.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cr3_pkg;

  localparam int COEF_W  = 16;               // Q8.8 coefficient width
  localparam int OUT_W   = 32;               // Q16.16 result width
  localparam int FRAC_W  = OUT_W / 2;        // result fraction bits
  localparam int PROD2_W = 2 * COEF_W;       // pair product
  localparam int PROD3_W = 3 * COEF_W;       // triple product
  localparam int DET_W   = PROD3_W + 3;      // sum of six triple products
  localparam int MAG_W   = DET_W - 1;        // determinant magnitude
  localparam int REM_W   = MAG_W + 1;        // partial remainder
  localparam int QBITS   = OUT_W;            // quotient bits kept
  localparam int NDET    = 4;                // main plus three column dets

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_r0c0;
    logic signed [COEF_W-1:0] coef_r0c1;
    logic signed [COEF_W-1:0] coef_r0c2;
    logic signed [COEF_W-1:0] coef_r1c0;
    logic signed [COEF_W-1:0] coef_r1c1;
    logic signed [COEF_W-1:0] coef_r1c2;
    logic signed [COEF_W-1:0] coef_r2c0;
    logic signed [COEF_W-1:0] coef_r2c1;
    logic signed [COEF_W-1:0] coef_r2c2;
    logic signed [COEF_W-1:0] rhs_0;
    logic signed [COEF_W-1:0] rhs_1;
    logic signed [COEF_W-1:0] rhs_2;
  } in_item_t;

  typedef struct packed {
    logic                    solvable;
    logic signed [OUT_W-1:0] sol_x;
    logic signed [OUT_W-1:0] sol_y;
    logic signed [OUT_W-1:0] sol_z;
  } out_item_t;

  // Determinants handed from the front end to the divider back end
  typedef struct packed {
    logic                    solvable;
    logic signed [DET_W-1:0] det_a;
    logic signed [DET_W-1:0] det_x;
    logic signed [DET_W-1:0] det_y;
    logic signed [DET_W-1:0] det_z;
  } det_item_t;

endpackage
`default_nettype wire

/* rtl/core/cramer_3x3_linear_solver_unit.sv */
// Top level of the 3x3 Cramer's rule solver.
// Instantiates cr3_front, cr3_queue and cr3_back; uses cr3_pkg.
//
// Usage:
//   Input queue side: drive in_data and in_push; a transfer happens on a
//   rising edge with in_push high and in_full low. Each item is a 3x3
//   Q8.8 matrix plus a Q8.8 right-hand side.
//   Result queue side: out_data holds the oldest result while out_empty is
//   low; a transfer happens on a rising edge with out_pop high.
//   Result: solvable flag and x, y, z in Q16.16, truncated toward zero and
//   saturated; all zero when the determinant is zero.
// Pipeline: 38 register stages (3 determinant, 1 queue, 1 entry,
//   32 division, result reg).
// Throughput: one system per cycle while results are popped, set by the
//   one-bit-per-stage divider pipeline and the product and sum stages.
// Stall: when out_pop stays low the divider pipeline holds, the 2-entry
//   queue fills, then the front holds and in_full rises.
// Reset: synchronous active-low rst_n empties every stage; no state is kept
//   between systems.
`timescale 1ns / 1ps
`default_nettype none
module cramer_3x3_linear_solver_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire cr3_pkg::in_item_t in_data,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output cr3_pkg::out_item_t     out_data
);

  logic               f_valid, f_ready, b_valid, b_ready;
  cr3_pkg::det_item_t f_data, b_data;

  cr3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .det_valid (f_valid),
    .det_ready (f_ready),
    .det_data  (f_data)
  );

  cr3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  cr3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .det_valid (b_valid),
    .det_ready (b_ready),
    .det_data  (b_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/cr3_front.sv */
// Front end: accepts systems and computes the four determinants exactly.
// Three register stages (pair product, triple product, sum); uses cr3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cr3_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire cr3_pkg::in_item_t in_data,
  output logic                   in_full,
  output logic                   det_valid,
  input  wire logic              det_ready,
  output cr3_pkg::det_item_t     det_data
);

  // Cofactor expansion terms: m[A]*m[B]*m[C], signs + - - + + -
  localparam int IA [6] = '{0, 0, 1, 1, 2, 2};
  localparam int IB [6] = '{4, 7, 3, 5, 3, 6};
  localparam int IC [6] = '{8, 5, 8, 6, 7, 4};
  localparam bit NEG [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  logic en;
  logic v1_r, v2_r, v3_r;

  logic signed [cr3_pkg::COEF_W-1:0]  m     [cr3_pkg::NDET][9];
  logic signed [cr3_pkg::COEF_W-1:0]  rhs   [3];
  logic signed [cr3_pkg::PROD2_W-1:0] p1_nxt[cr3_pkg::NDET][6];
  logic signed [cr3_pkg::PROD2_W-1:0] p1_r  [cr3_pkg::NDET][6];
  logic signed [cr3_pkg::COEF_W-1:0]  t1_nxt[cr3_pkg::NDET][6];
  logic signed [cr3_pkg::COEF_W-1:0]  t1_r  [cr3_pkg::NDET][6];
  logic signed [cr3_pkg::PROD3_W-1:0] p2_nxt[cr3_pkg::NDET][6];
  logic signed [cr3_pkg::PROD3_W-1:0] p2_r  [cr3_pkg::NDET][6];
  logic signed [cr3_pkg::DET_W-1:0]   d_nxt [cr3_pkg::NDET];
  logic signed [cr3_pkg::DET_W-1:0]   d_r   [cr3_pkg::NDET];

  // Whole front advances unless its last stage is held by the queue
  assign en      = !v3_r || det_ready;
  assign in_full = !en;

  // Original matrix and the three column-replaced matrices
  always_comb begin
    rhs[0] = in_data.rhs_0;
    rhs[1] = in_data.rhs_1;
    rhs[2] = in_data.rhs_2;
    m[0][0] = in_data.coef_r0c0;
    m[0][1] = in_data.coef_r0c1;
    m[0][2] = in_data.coef_r0c2;
    m[0][3] = in_data.coef_r1c0;
    m[0][4] = in_data.coef_r1c1;
    m[0][5] = in_data.coef_r1c2;
    m[0][6] = in_data.coef_r2c0;
    m[0][7] = in_data.coef_r2c1;
    m[0][8] = in_data.coef_r2c2;
    for (int k = 1; k < cr3_pkg::NDET; k++) begin
      for (int i = 0; i < 9; i++) begin
        m[k][i] = ((i % 3) == (k - 1)) ? rhs[i / 3] : m[0][i];
      end
    end
  end

  // Stage math
  always_comb begin
    for (int k = 0; k < cr3_pkg::NDET; k++) begin
      d_nxt[k] = '0;
      for (int j = 0; j < 6; j++) begin
        p1_nxt[k][j] = m[k][IA[j]] * m[k][IB[j]];
        t1_nxt[k][j] = m[k][IC[j]];
        p2_nxt[k][j] = p1_r[k][j] * t1_r[k][j];
        if (NEG[j]) begin
          d_nxt[k] = d_nxt[k] - cr3_pkg::DET_W'(p2_r[k][j]);
        end else begin
          d_nxt[k] = d_nxt[k] + cr3_pkg::DET_W'(p2_r[k][j]);
        end
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      t1_r <= t1_nxt;
      p2_r <= p2_nxt;
      d_r  <= d_nxt;
    end
  end

  // Classify: a zero main determinant marks the system unsolvable
  assign det_valid         = v3_r;
  assign det_data.solvable = (d_r[0] != '0);
  assign det_data.det_a    = d_r[0];
  assign det_data.det_x    = d_r[1];
  assign det_data.det_y    = d_r[2];
  assign det_data.det_z    = d_r[3];

endmodule
`default_nettype wire

/* rtl/core/cr3_queue.sv */
// Two-entry queue between the determinant front end and the divider back end.
// Uses cr3_pkg::det_item_t.
`timescale 1ns / 1ps
`default_nettype none
module cr3_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire cr3_pkg::det_item_t wr_data,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output cr3_pkg::det_item_t      rd_data
);

  cr3_pkg::det_item_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

/* rtl/core/cr3_back.sv */
// Back end: three lanes of pipelined restoring division, one quotient bit per
// stage, then sign and saturation into the result register. Uses cr3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cr3_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               det_valid,
  output logic                    det_ready,
  input  wire cr3_pkg::det_item_t det_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output cr3_pkg::out_item_t      out_data
);

  localparam int NST = cr3_pkg::QBITS + 1;

  typedef struct packed {
    logic [cr3_pkg::REM_W-1:0] rem;
    logic [cr3_pkg::QBITS-1:0] bits;
    logic [cr3_pkg::QBITS-1:0] quo;
    logic                      neg;
    logic                      ovf;
  } lane_t;

  logic en;
  logic out_valid_r;
  cr3_pkg::out_item_t out_r, out_nxt;

  logic                      vld_r  [NST];
  logic                      sv_r   [NST];
  logic                      sv_nxt [NST];
  logic [cr3_pkg::MAG_W-1:0] dm_r   [NST];
  logic [cr3_pkg::MAG_W-1:0] dm_nxt [NST];
  lane_t                     ln_r   [NST][3];
  lane_t                     ln_nxt [NST][3];

  logic signed [cr3_pkg::DET_W-1:0] num [3];
  logic [cr3_pkg::DET_W-1:0]         dabs, nabs;
  logic                              dneg, nneg;
  logic [cr3_pkg::REM_W-1:0]         trial;
  logic [cr3_pkg::QBITS-1:0]         res [3];

  assign en        = !out_valid_r || out_pop;
  assign det_ready = en;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assign num[0] = det_data.det_x;
  assign num[1] = det_data.det_y;
  assign num[2] = det_data.det_z;

  // Entry stage: magnitudes, signs and the overflow test
  // (quotient needs more than QBITS bits when |num| >= |det| * 2^FRAC_W)
  always_comb begin
    dneg      = det_data.det_a[cr3_pkg::DET_W-1];
    dabs      = dneg ? -det_data.det_a : det_data.det_a;
    dm_nxt[0] = dabs[cr3_pkg::MAG_W-1:0];
    sv_nxt[0] = det_data.solvable;
    nneg      = 1'b0;
    nabs      = '0;
    for (int k = 0; k < 3; k++) begin
      nneg = num[k][cr3_pkg::DET_W-1];
      nabs = nneg ? -num[k] : num[k];
      ln_nxt[0][k].neg  = nneg ^ dneg;
      ln_nxt[0][k].ovf  = {{cr3_pkg::FRAC_W{1'b0}}, nabs[cr3_pkg::MAG_W-1:0]} >=
                          {dabs[cr3_pkg::MAG_W-1:0], {cr3_pkg::FRAC_W{1'b0}}};
      ln_nxt[0][k].rem  = cr3_pkg::REM_W'(nabs[cr3_pkg::MAG_W-1:cr3_pkg::FRAC_W]);
      ln_nxt[0][k].bits = {nabs[cr3_pkg::FRAC_W-1:0], {cr3_pkg::FRAC_W{1'b0}}};
      ln_nxt[0][k].quo  = '0;
    end
  end

  // Division stages: shift in one dividend bit, compare and subtract
  always_comb begin
    trial = '0;
    for (int s = 1; s < NST; s++) begin
      dm_nxt[s] = dm_r[s-1];
      sv_nxt[s] = sv_r[s-1];
      for (int k = 0; k < 3; k++) begin
        trial = {ln_r[s-1][k].rem[cr3_pkg::REM_W-2:0],
                 ln_r[s-1][k].bits[cr3_pkg::QBITS-1]};
        ln_nxt[s][k].neg  = ln_r[s-1][k].neg;
        ln_nxt[s][k].ovf  = ln_r[s-1][k].ovf;
        ln_nxt[s][k].bits = {ln_r[s-1][k].bits[cr3_pkg::QBITS-2:0], 1'b0};
        if (trial >= {1'b0, dm_r[s-1]}) begin
          ln_nxt[s][k].rem = trial - {1'b0, dm_r[s-1]};
          ln_nxt[s][k].quo = {ln_r[s-1][k].quo[cr3_pkg::QBITS-2:0], 1'b1};
        end else begin
          ln_nxt[s][k].rem = trial;
          ln_nxt[s][k].quo = {ln_r[s-1][k].quo[cr3_pkg::QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // Sign, saturation and the unsolvable case
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!sv_r[NST-1]) begin
        res[k] = '0;
      end else if (ln_r[NST-1][k].ovf || ln_r[NST-1][k].quo[cr3_pkg::QBITS-1]) begin
        res[k] = ln_r[NST-1][k].neg ? {1'b1, {(cr3_pkg::QBITS-1){1'b0}}}
                                    : {1'b0, {(cr3_pkg::QBITS-1){1'b1}}};
      end else begin
        res[k] = ln_r[NST-1][k].neg ? -ln_r[NST-1][k].quo : ln_r[NST-1][k].quo;
      end
    end
    out_nxt.solvable = sv_r[NST-1];
    out_nxt.sol_x    = res[0];
    out_nxt.sol_y    = res[1];
    out_nxt.sol_z    = res[2];
  end

  // Valid chain and result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= det_valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
      out_valid_r <= vld_r[NST-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r  <= dm_nxt;
      sv_r  <= sv_nxt;
      ln_r  <= ln_nxt;
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the 3x3 Cramer's rule solver.
// Drives cramer_3x3_linear_solver_unit with cr3_pkg item types and
// compares each result against an internal determinant/quotient predictor.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  cr3_pkg::in_item_t  in_data;
  logic               out_empty;
  logic               out_pop;
  cr3_pkg::out_item_t out_data;

  cr3_pkg::out_item_t expected_solutions[$];
  int                 error_count;
  int                 cycle_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 pop_hold_left;

  cramer_3x3_linear_solver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact 3x3 determinant, row-major entries
  function automatic longint det3(longint m[9]);
    return m[0] * m[4] * m[8] - m[0] * m[7] * m[5] - m[1] * m[3] * m[8]
         + m[1] * m[5] * m[6] + m[2] * m[3] * m[7] - m[2] * m[6] * m[4];
  endfunction

  // num * 2^FRAC_W / den, truncated toward zero, saturated to OUT_W bits
  function automatic logic [cr3_pkg::OUT_W-1:0] q16_ratio(longint num, longint den);
    logic [95:0] nm;
    logic [95:0] dm;
    logic [95:0] q;
    logic [95:0] neg_cap;
    logic [95:0] pos_cap;
    bit          neg;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? 96'(-num) : 96'(num);
    dm = (den < 0) ? 96'(-den) : 96'(den);
    q = (nm << cr3_pkg::FRAC_W) / dm;
    neg_cap = 96'(1) << (cr3_pkg::OUT_W - 1);
    pos_cap = neg_cap - 1;
    if (neg) begin
      if (q > neg_cap) q = neg_cap;
      return -q[cr3_pkg::OUT_W-1:0];
    end
    if (q > pos_cap) q = pos_cap;
    return q[cr3_pkg::OUT_W-1:0];
  endfunction

  // Predicted result for one system
  function automatic cr3_pkg::out_item_t solve_system(cr3_pkg::in_item_t s);
    longint             m[9];
    longint             c[3];
    longint             t[9];
    longint             d;
    cr3_pkg::out_item_t r;
    m = '{s.coef_r0c0, s.coef_r0c1, s.coef_r0c2, s.coef_r1c0, s.coef_r1c1,
          s.coef_r1c2, s.coef_r2c0, s.coef_r2c1, s.coef_r2c2};
    c = '{s.rhs_0, s.rhs_1, s.rhs_2};
    r = '0;
    d = det3(m);
    if (d == 0) return r;
    r.solvable = 1'b1;
    t = m; t[0] = c[0]; t[3] = c[1]; t[6] = c[2];
    r.sol_x = q16_ratio(det3(t), d);
    t = m; t[1] = c[0]; t[4] = c[1]; t[7] = c[2];
    r.sol_y = q16_ratio(det3(t), d);
    t = m; t[2] = c[0]; t[5] = c[1]; t[8] = c[2];
    r.sol_z = q16_ratio(det3(t), d);
    return r;
  endfunction

  function automatic cr3_pkg::in_item_t pack_system(int v[12]);
    cr3_pkg::in_item_t s;
    s.coef_r0c0 = v[0]; s.coef_r0c1 = v[1]; s.coef_r0c2 = v[2];
    s.coef_r1c0 = v[3]; s.coef_r1c1 = v[4]; s.coef_r1c2 = v[5];
    s.coef_r2c0 = v[6]; s.coef_r2c1 = v[7]; s.coef_r2c2 = v[8];
    s.rhs_0 = v[9]; s.rhs_1 = v[10]; s.rhs_2 = v[11];
    return s;
  endfunction

  // Random system: full-range, small-valued, singular or well-conditioned
  function automatic cr3_pkg::in_item_t random_system();
    int v[12];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 12; i++) begin
      if (kind < 3) v[i] = $signed(16'($urandom));
      else v[i] = int'($urandom_range(1023)) - 512;
    end
    if (kind == 6) begin
      for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
    end else if (kind == 7) begin
      for (int i = 0; i < 3; i++) v[3 * i + $urandom_range(2)] = 0;
      v[2] = 0; v[5] = 0; v[8] = 0;
    end else if (kind == 8) begin
      v[0] = 256 + $urandom_range(4096); v[4] = 256 + $urandom_range(4096);
      v[8] = 256 + $urandom_range(4096);
    end
    return pack_system(v);
  endfunction

  // One input transfer; returns once the block has taken it
  task automatic send_system(cr3_pkg::in_item_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_full);
  endtask

  task automatic end_input();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  // Record the expectation for every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) expected_solutions.push_back(solve_system(in_data));
  end

  // Result checker
  always @(posedge clk) begin
    cr3_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_solutions.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_solutions.pop_front();
        if (out_data.solvable !== want.solvable) begin
          $display("%0t: solvable exp %b got %b", $time, want.solvable, out_data.solvable);
          error_count++;
        end
        if (out_data.sol_x !== want.sol_x) begin
          $display("%0t: sol_x exp %h got %h", $time, want.sol_x, out_data.sol_x);
          error_count++;
        end
        if (out_data.sol_y !== want.sol_y) begin
          $display("%0t: sol_y exp %h got %h", $time, want.sol_y, out_data.sol_y);
          error_count++;
        end
        if (out_data.sol_z !== want.sol_z) begin
          $display("%0t: sol_z exp %h got %h", $time, want.sol_z, out_data.sol_z);
          error_count++;
        end
      end
    end
  end

  // Receiver: random pops, or a counted hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold_left > 0) begin
      pop_hold_left <= pop_hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_system(pack_system('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_system(pack_system('{256, 0, 0, 0, 256, 0, 0, 0, 256, 256, -512, 768}));
    send_system(pack_system('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767,
                              32767, -32768, 1}));
    send_system(pack_system('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768,
                              -32768, 32767, -1}));
    send_system(pack_system('{-32768, -32768, -32768, -32768, 32767, -32768,
                              -32768, -32768, 32767, -32768, -32768, -32768}));
    send_system(pack_system('{32767, -32768, 32767, -32768, 32767, 32767,
                              32767, 32767, -32768, 32767, -32768, 32767}));
    // tiny determinant, huge numerators: saturate both ways
    send_system(pack_system('{1, 0, 0, 0, 1, 0, 0, 0, 1, 32767, -32768, 1}));
    send_system(pack_system('{-1, 0, 0, 0, 1, 0, 0, 0, 1, 32767, -32768, 100}));
    // exactly the negative limit, then exact halves of both signs
    send_system(pack_system('{1, 0, 0, 0, 1, 0, 0, 0, 1, -32768, 0, 0}));
    send_system(pack_system('{2, 0, 0, 0, 2, 0, 0, 0, 2, 65535 - 65536, 1, -1}));
    // inexact quotients, truncation toward zero on both signs
    send_system(pack_system('{3, 0, 0, 0, 7, 0, 0, 0, -3, 1, -1, 1}));
    send_system(pack_system('{768, 1, 0, 0, -768, 0, 5, 0, 11, -256, 256, 1}));
    // singular: repeated row, zero column, proportional rows
    send_system(pack_system('{1, 2, 3, 4, 5, 6, 1, 2, 3, 9, 9, 9}));
    send_system(pack_system('{0, 2, 3, 0, 5, 6, 0, -7, 8, 1, 1, 1}));
    send_system(pack_system('{1, 2, 3, 2, 4, 6, -3, 1, 4, 5, 10, 0}));
    send_system(pack_system('{-32768, 32767, 1, -32768, 32767, 1, 5, 6, 7, 0, 0, 0}));
    // dense general systems
    send_system(pack_system('{512, -256, 128, 64, 1024, -32, 7, 9, 2048,
                              1000, -2000, 3000}));
    send_system(pack_system('{-1, -1, 1, 1, -1, -1, -1, 1, -1, -1, 1, -1}));
    end_input();
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) send_system(random_system());
    end_input();
  endtask

  // Long receiver hold-off while input keeps coming: the block must fill and stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pop_hold_left = 300;
    for (int i = 0; i < 80; i++) send_system(random_system());
    end_input();
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 12;
    recv_idle_pct = 76;
    pop_hold_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(600, 12, 76);
    test_random(600, 76, 12);
    test_random(550, 0, 0);
    test_backpressure();

    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0 && expected_solutions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
